/* hdl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/baro_pkg.sv */
`default_nettype none
package baro_pkg;
    localparam int unsigned DIV_BITS = 32;
    // x / 133 == (x * MMHG_RECIP) >> MMHG_SHIFT for every 32-bit x
    localparam logic [31:0] MMHG_RECIP = 32'd4133502361;
    localparam int unsigned MMHG_SHIFT = 39;

    localparam logic [2:0] CFG_TEMP_CAL  = 3'd0;
    localparam logic [2:0] CFG_PRESS_A   = 3'd1;
    localparam logic [2:0] CFG_PRESS_B   = 3'd2;
    localparam logic [2:0] CFG_PRESS_C   = 3'd3;
    localparam logic [2:0] CFG_TEMP_OSR  = 3'd4;
    localparam logic [2:0] CFG_PRESS_OSR = 3'd5;

    typedef struct packed {
        logic [47:0] temp_cal;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [2:0]  temp_osr;
        logic [2:0]  press_osr;
    } t_cal;

    // Arithmetic right shift of a 32-bit word.
    function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned s);
        sra = 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sw(input logic [47:0] r, input int unsigned k);
        logic [15:0] w;
        w = r[16*k +: 16];
        sw = {{16{w[15]}}, w};
    endfunction

    function automatic logic [31:0] uw(input logic [47:0] r, input int unsigned k);
        uw = {16'd0, r[16*k +: 16]};
    endfunction
endpackage
`default_nettype wire

/* hdl/baro_div.sv */
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module baro_div
    import baro_pkg::*;
#(
    parameter int unsigned SBW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [31:0]     i_num,
    input  wire logic [31:0]     i_den,
    input  wire logic [SBW-1:0]  i_sb,
    output logic                 o_valid,
    output logic [31:0]          o_quo,
    output logic [SBW-1:0]       o_sb
);
    localparam int unsigned N = DIV_BITS;
    logic [N-1:0]      r_vld;
    logic [31:0]       r_rem [N];
    logic [31:0]       r_q   [N];
    logic [31:0]       r_d   [N];
    logic [SBW-1:0]    r_sb  [N];

    for (genvar k = 0; k < N; k++) begin : g_st
        logic           v_in;
        logic [31:0]    rem_in, q_in, d_in;
        logic [SBW-1:0] sb_in;
        logic [32:0]    n_t;
        logic [32:0]    n_s;
        if (k == 0) begin : g_head
            assign v_in   = i_valid;
            assign rem_in = 32'd0;
            assign q_in   = i_num;
            assign d_in   = i_den;
            assign sb_in  = i_sb;
        end else begin : g_body
            assign v_in   = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign d_in   = r_d[k-1];
            assign sb_in  = r_sb[k-1];
        end
        assign n_t = {rem_in, q_in[31]};
        assign n_s = n_t - {1'b0, d_in};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
            if (i_en) begin
                r_rem[k] <= n_s[32] ? n_t[31:0] : n_s[31:0];
                r_q[k]   <= {q_in[30:0], ~n_s[32]};
                r_d[k]   <= d_in;
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quo   = r_q[N-1];
    assign o_sb    = r_sb[N-1];
endmodule
`default_nettype wire

/* hdl/baro_front.sv */
`default_nettype none
// Temperature and pressure-coefficient polynomial, registered stages.
module baro_front
    import baro_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [23:0] i_raw_p,
    input  wire logic [23:0] i_raw_t,
    input  wire t_cal        i_cal,
    output logic             o_valid,
    output logic [31:0]      o_temp,
    output logic [31:0]      o_num,
    output logic [31:0]      o_den,
    output logic             o_big
);
    logic [7:0]  r_v;
    // stage 1: adc values
    logic [31:0] r1_at, r1_ap;
    // stage 2
    logic [31:0] r2_a, r2_dd, r2_ap;
    // stage 3
    logic [31:0] r3_v1, r3_b, r3_ap;
    // stage 4: fine
    logic [31:0] r4_fine, r4_ap;
    // stage 5
    logic [31:0] r5_temp, r5_sq, r5_v1p5, r5_p2v1, r5_ap;
    // stage 6
    logic [31:0] r6_temp, r6_v2a, r6_p3, r6_p2v1, r6_ap;
    // stage 7
    logic [31:0] r7_temp, r7_v2, r7_ap, r7_v1;
    // stage 8
    logic [31:0] r8_temp, r8_num, r8_den;

    logic [31:0] n_t1, n_t2, n_t3, n_p1, n_p2, n_p3, n_p4, n_p5, n_p6;
    logic [31:0] n_at, n_ap, n_v1, n_num0;
    always_comb begin
        n_t1 = uw(i_cal.temp_cal, 0);
        n_t2 = sw(i_cal.temp_cal, 1);
        n_t3 = sw(i_cal.temp_cal, 2);
        n_p1 = uw(i_cal.press_a, 0);
        n_p2 = sw(i_cal.press_a, 1);
        n_p3 = sw(i_cal.press_a, 2);
        n_p4 = sw(i_cal.press_b, 0);
        n_p5 = sw(i_cal.press_b, 1);
        n_p6 = sw(i_cal.press_b, 2);
        n_at = {8'd0, i_raw_t} >> (4'd9 - {1'b0, i_cal.temp_osr});
        n_ap = {8'd0, i_raw_p} >> (4'd9 - {1'b0, i_cal.press_osr});
        n_v1 = sra(r4_fine, 1) - 32'd64000;
        n_num0 = ((32'd1048576 - r7_ap) - sra(r7_v2, 12)) * 32'd3125;
    end

    logic [31:0] n_q, n_v1f;
    always_comb begin
        n_q = sra(n_v1, 2);
        n_v1f = sra(sra(r6_p3, 3) + sra(r6_p2v1, 1), 18);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
        if (i_en) begin
            r1_at <= n_at;
            r1_ap <= n_ap;

            r2_a  <= (r1_at >> 3) - (n_t1 << 1);
            r2_dd <= (r1_at >> 4) - n_t1;
            r2_ap <= r1_ap;

            r3_v1 <= sra(r2_a * n_t2, 11);
            r3_b  <= sra(r2_dd * r2_dd, 12);
            r3_ap <= r2_ap;

            r4_fine <= r3_v1 + sra(r3_b * n_t3, 14);
            r4_ap   <= r3_ap;

            r5_temp <= sra(r4_fine * 32'd5 + 32'd128, 8);
            r5_sq   <= n_q * n_q;
            r5_v1p5 <= n_v1 * n_p5;
            r5_p2v1 <= n_p2 * n_v1;
            r5_ap   <= r4_ap;

            r6_temp <= r5_temp;
            r6_v2a  <= sra(sra(r5_sq, 11) * n_p6 + (r5_v1p5 << 1), 2) + (n_p4 << 16);
            r6_p3   <= n_p3 * sra(r5_sq, 13);
            r6_p2v1 <= r5_p2v1;
            r6_ap   <= r5_ap;

            r7_temp <= r6_temp;
            r7_v2   <= r6_v2a;
            r7_ap   <= r6_ap;
            r7_v1   <= n_v1f;

            r8_temp <= r7_temp;
            r8_num  <= n_num0;
            r8_den  <= sra((32'd32768 + r7_v1) * n_p1, 15);
        end
    end

    assign o_valid = r_v[7];
    assign o_temp  = r8_temp;
    assign o_big   = r8_num[31];
    assign o_num   = r8_num[31] ? r8_num : {r8_num[30:0], 1'b0};
    assign o_den   = r8_den;
endmodule
`default_nettype wire

/* hdl/baro_back.sv */
`default_nettype none
// Pressure correction after the division; registered stages.
module baro_back
    import baro_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_quo,
    input  wire logic [31:0] i_temp,
    input  wire logic        i_big,
    input  wire logic        i_ok,
    input  wire logic [47:0] i_cal_c,
    output logic             o_valid,
    output logic [31:0]      o_temp,
    output logic [31:0]      o_p,
    output logic             o_ok
);
    logic [2:0]  r_v;
    logic [31:0] r1_p, r1_sq, r1_v2, r1_t;
    logic [31:0] r2_p, r2_v1, r2_v2, r2_t;
    logic [31:0] r3_p, r3_t;
    logic [2:0]  r_ok;

    logic [31:0] n_p, n_p7, n_p8, n_p9;
    always_comb begin
        n_p  = i_big ? {i_quo[30:0], 1'b0} : i_quo;
        n_p7 = sw(i_cal_c, 0);
        n_p8 = sw(i_cal_c, 1);
        n_p9 = sw(i_cal_c, 2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
        if (i_en) begin
            r1_p  <= n_p;
            r1_sq <= (n_p >> 3) * (n_p >> 3);
            r1_v2 <= (n_p >> 2) * n_p8;
            r1_t  <= i_temp;
            r_ok  <= {r_ok[1:0], i_ok};

            r2_p  <= r1_p;
            r2_v1 <= sra(n_p9 * (r1_sq >> 13), 12);
            r2_v2 <= sra(r1_v2, 13);
            r2_t  <= r1_t;

            r3_p  <= r_ok[1] ? r2_p + sra(r2_v1 + r2_v2 + n_p7, 4) : 32'd0;
            r3_t  <= r2_t;
        end
    end

    assign o_valid = r_v[2];
    assign o_temp  = r3_t;
    assign o_p     = r3_p;
    assign o_ok    = r_ok[2];
endmodule
`default_nettype wire

/* hdl/baro_compensation_int32.sv */
// Pipeline: 8 front stages + 32 divider stages + 3 correction stages +
//   1 mmHg multiply stage + 1 output register.
// Throughput: one word per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous active low; clears valid bits, calibration to zero,
//   both oversampling codes to five.
`default_nettype none
module baro_compensation_int32
    import baro_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [23:0] i_raw_press_word,
    input  wire logic [23:0] i_raw_temp_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_temp_centideg,
    output logic [31:0]      o_pressure_pa,
    output logic [24:0]      o_pressure_mmhg,
    output logic             o_pressure_valid,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);
`include "assert_macros.svh"
    t_cal r_cal;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '{48'd0, 48'd0, 48'd0, 48'd0, 3'd5, 3'd5};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP_CAL:  r_cal.temp_cal  <= i_cfg_data;
                CFG_PRESS_A:   r_cal.press_a   <= i_cfg_data;
                CFG_PRESS_B:   r_cal.press_b   <= i_cfg_data;
                CFG_PRESS_C:   r_cal.press_c   <= i_cfg_data;
                CFG_TEMP_OSR:  r_cal.temp_osr  <= i_cfg_data[2:0];
                CFG_PRESS_OSR: r_cal.press_osr <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Whole pipe advances when the output register is free or taken.
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    logic        f_v, f_big;
    logic [31:0] f_temp, f_num, f_den;
    baro_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_valid && w_en),
        .i_raw_p(i_raw_press_word), .i_raw_t(i_raw_temp_word), .i_cal(r_cal),
        .o_valid(f_v), .o_temp(f_temp), .o_num(f_num), .o_den(f_den), .o_big(f_big)
    );

    // Zero divisor: divide by one, result forced to zero later.
    logic        f_ok;
    assign f_ok = (f_den != 32'd0);

    logic        d_v;
    logic [31:0] d_q;
    logic [33:0] d_sb;
    baro_div #(.SBW(34)) u_pdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(f_v),
        .i_num(f_num), .i_den(f_ok ? f_den : 32'd1), .i_sb({f_temp, f_big, f_ok}),
        .o_valid(d_v), .o_quo(d_q), .o_sb(d_sb)
    );

    logic        b_v, b_ok;
    logic [31:0] b_t, b_p;
    baro_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(d_v),
        .i_quo(d_q), .i_temp(d_sb[33:2]), .i_big(d_sb[1]), .i_ok(d_sb[0]),
        .i_cal_c(r_cal.press_c),
        .o_valid(b_v), .o_temp(b_t), .o_p(b_p), .o_ok(b_ok)
    );

    // mmHg: pressure / 133 as a reciprocal multiply, exact over the full
    // 32-bit range; temp/pa ride along.
    logic        r_m_v, r_m_ok;
    logic [31:0] r_m_t, r_m_p;
    logic [63:0] r_m_prod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_en) begin
            r_m_v <= b_v;
        end
        if (w_en) begin
            r_m_t    <= b_t;
            r_m_p    <= b_p;
            r_m_ok   <= b_ok;
            r_m_prod <= {32'd0, b_p} * {32'd0, MMHG_RECIP};
        end
    end

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_m_v;
        end
        if (w_en) begin
            o_temp_centideg  <= r_m_t;
            o_pressure_pa    <= r_m_p;
            o_pressure_valid <= r_m_ok;
            o_pressure_mmhg  <= r_m_prod[MMHG_SHIFT +: 25];
        end
    end
    assign o_valid = r_ov;

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_pressure_pa))
    `ASSERT_IMPL(a_inv, i_clk, i_rst_n, o_valid && !o_pressure_valid,
        o_pressure_pa == 32'd0 && o_pressure_mmhg == 25'd0)
    `ASSERT_IMPL(a_rdy, i_clk, i_rst_n, !o_valid, o_ready)
endmodule
`default_nettype wire

/* bench/baro_checker.sv */
`default_nettype none
module baro_checker
    import baro_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [23:0] i_raw_press_word,
    input  wire logic [23:0] i_raw_temp_word,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_temp_centideg,
    input  wire logic [31:0] i_pressure_pa,
    input  wire logic [24:0] i_pressure_mmhg,
    input  wire logic        i_pressure_valid,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] temp_centideg;
        logic [31:0] pressure_pa;
        logic [24:0] pressure_mmhg;
        logic        pressure_valid;
    } reading_t;

    logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
    logic [2:0]  osr_temp, osr_press;
    reading_t    expected_readings[$];

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
        logic [31:0] r;
        r = x >> s;
        if (x[31])
            r = ~((~x) >> s);
        return r;
    endfunction

    function automatic logic [31:0] sx16(input logic [47:0] r, input int unsigned k);
        logic [15:0] w;
        w = r[16*k +: 16];
        return {{16{w[15]}}, w};
    endfunction

    function automatic reading_t compensate(input logic [23:0] rp, input logic [23:0] rt);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] adc_p, adc_t, v1, v2, d, fine, temp, p, q, sq, a, b;
        reading_t r;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = sx16(cal_temp, 1);
        t3 = sx16(cal_temp, 2);
        p1 = {16'd0, cal_pa[15:0]};
        p2 = sx16(cal_pa, 1);
        p3 = sx16(cal_pa, 2);
        p4 = sx16(cal_pb, 0);
        p5 = sx16(cal_pb, 1);
        p6 = sx16(cal_pb, 2);
        p7 = sx16(cal_pc, 0);
        p8 = sx16(cal_pc, 1);
        p9 = sx16(cal_pc, 2);
        adc_p = {8'd0, rp} >> (9 - osr_press);
        adc_t = {8'd0, rt} >> (9 - osr_temp);
        // temperature
        a = (adc_t >> 3) - (t1 << 1);
        a = a * t2;
        v1 = asr(a, 11);
        d = (adc_t >> 4) - t1;
        a = d * d;
        a = asr(a, 12) * t3;
        v2 = asr(a, 14);
        fine = v1 + v2;
        a = fine * 32'd5 + 32'd128;
        temp = asr(a, 8);
        // pressure
        v1 = asr(fine, 1) - 32'd64000;
        q = asr(v1, 2);
        sq = q * q;
        v2 = asr(sq, 11) * p6;
        a = v1 * p5;
        v2 = v2 + (a << 1);
        v2 = asr(v2, 2) + (p4 << 16);
        a = p3 * asr(sq, 13);
        b = p2 * v1;
        v1 = asr(asr(a, 3) + asr(b, 1), 18);
        a = (32'd32768 + v1) * p1;
        v1 = asr(a, 15);
        if (v1 == 32'd0) begin
            r.pressure_pa = '0;
            r.pressure_mmhg = '0;
            r.pressure_valid = 1'b0;
        end else begin
            p = ((32'd1048576 - adc_p) - asr(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000)
                p = (p << 1) / v1;
            else
                p = (p / v1) * 32'd2;
            a = (p >> 3) * (p >> 3);
            a = p9 * (a >> 13);
            v1 = asr(a, 12);
            a = (p >> 2) * p8;
            v2 = asr(a, 13);
            p = p + asr(v1 + v2 + p7, 4);
            r.pressure_pa = p;
            r.pressure_mmhg = 25'(p / 32'd133);
            r.pressure_valid = 1'b1;
        end
        r.temp_centideg = temp;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch word %0d: %s got %h want %h", o_checked, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end

    assign o_pending = expected_readings.size();

    always @(posedge i_clk) begin
        reading_t w;
        if (!i_rst_n) begin
            cal_temp <= '0;
            cal_pa <= '0;
            cal_pb <= '0;
            cal_pc <= '0;
            osr_temp <= 3'd5;
            osr_press <= 3'd5;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEMP_CAL:  cal_temp <= i_cfg_data;
                    CFG_PRESS_A:   cal_pa <= i_cfg_data;
                    CFG_PRESS_B:   cal_pb <= i_cfg_data;
                    CFG_PRESS_C:   cal_pc <= i_cfg_data;
                    CFG_TEMP_OSR:  osr_temp <= i_cfg_data[2:0];
                    CFG_PRESS_OSR: osr_press <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_readings.push_back(compensate(i_raw_press_word, i_raw_temp_word));
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    report("unexpected word", i_temp_centideg, '0);
                end else begin
                    w = expected_readings.pop_front();
                    if (i_temp_centideg !== w.temp_centideg)
                        report("temp_centideg", i_temp_centideg, w.temp_centideg);
                    if (i_pressure_pa !== w.pressure_pa)
                        report("pressure_pa", i_pressure_pa, w.pressure_pa);
                    if (i_pressure_mmhg !== w.pressure_mmhg)
                        report("pressure_mmhg", 32'(i_pressure_mmhg), 32'(w.pressure_mmhg));
                    if (i_pressure_valid !== w.pressure_valid)
                        report("pressure_valid", 32'(i_pressure_valid), 32'(w.pressure_valid));
                end
                o_checked++;
            end
        end
    end
endmodule
`default_nettype wire

/* bench/tb_baro_compensation_int32.sv */
`default_nettype none
module tb_baro_compensation_int32;
    import baro_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 240;
    localparam int DRAIN_WAIT  = 90;    // pipe is 45 deep
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG    = 3000;

    // typical factory calibration, keeps the polynomial in its sane region
    localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
    localparam logic [47:0] TYP_PA   = {16'd3024, 16'hD643, 16'd36477};
    localparam logic [47:0] TYP_PB   = {16'hFFF9, 16'd140, 16'd2855};
    localparam logic [47:0] TYP_PC   = {16'd6000, 16'hC6F8, 16'd15500};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [23:0] i_raw_press_word = '0;
    logic [23:0] i_raw_temp_word = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_temp_centideg;
    logic [31:0] o_pressure_pa;
    logic [24:0] o_pressure_mmhg;
    logic        o_pressure_valid;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;

    int fail_count, pending, checked;
    bit idle_on = 1'b1;     // random bubbles on both sides
    bit hold_req = 1'b0;    // ask sink for one long back-pressure stretch
    int stall_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    baro_compensation_int32 i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_raw_press_word, .i_raw_temp_word,
        .o_valid, .i_ready, .o_temp_centideg, .o_pressure_pa, .o_pressure_mmhg,
        .o_pressure_valid, .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    baro_checker i_checker (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_raw_press_word, .i_raw_temp_word,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_temp_centideg(o_temp_centideg), .i_pressure_pa(o_pressure_pa),
        .i_pressure_mmhg(o_pressure_mmhg), .i_pressure_valid(o_pressure_valid),
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    // sink: random bubbles, plus one long hold when requested
    initial begin
        int hold_left, burst;
        hold_left = 0;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles with no word moving and no config write
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
            $display("watchdog expired, %0d words still pending", pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [23:0] press, input logic [23:0] temp);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_press_word <= press;
        i_raw_temp_word <= temp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] t, input logic [47:0] a, input logic [47:0] b,
                            input logic [47:0] c, input logic [2:0] ot, input logic [2:0] op);
        write_reg(CFG_TEMP_CAL, t);
        write_reg(CFG_PRESS_A, a);
        write_reg(CFG_PRESS_B, b);
        write_reg(CFG_PRESS_C, c);
        write_reg(CFG_TEMP_OSR, {45'd0, ot});
        write_reg(CFG_PRESS_OSR, {45'd0, op});
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // small signed jitter on every 16-bit word of a calibration register
    function automatic logic [47:0] jitter(input logic [47:0] r);
        logic [47:0] j;
        for (int k = 0; k < 3; k++)
            j[16*k +: 16] = r[16*k +: 16] + 16'($urandom_range(0, 511)) - 16'd256;
        return j;
    endfunction

    initial begin
        logic [23:0] rp, rt;
        logic [2:0] ot, op;
        int kind;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration is all zero: divisor is zero, pressure invalid
        send_word(24'h000000, 24'h000000);
        send_word(24'hFFFFFF, 24'hFFFFFF);
        send_word(24'h655AC0, 24'h7EED00);
        drain();

        // typical part, field extremes and mid-scale readings
        load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, 3'd5, 3'd5);
        send_word(24'h000000, 24'h000000);
        send_word(24'hFFFFFF, 24'hFFFFFF);
        send_word(24'h000000, 24'hFFFFFF);
        send_word(24'hFFFFFF, 24'h000000);
        send_word(24'h655AC0, 24'h7EED00);
        send_word(24'h555555, 24'hAAAAAA);
        send_word(24'hAAAAAA, 24'h555555);
        drain();

        // oversampling codes six and seven, shifts of three and two
        load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, 3'd7, 3'd6);
        send_word(24'h655AC0, 24'h7EED00);
        send_word(24'hFFFFFF, 24'h000001);
        send_word(24'h123456, 24'hFEDCBA);
        drain();

        // shortest oversampling code plus extreme words: wraps and big numerators
        load_cal({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF}, 3'd0, 3'd0);
        send_word(24'h000000, 24'hFFFFFF);
        send_word(24'hFFFFFF, 24'h000000);
        send_word(24'h7FFFFF, 24'h800000);
        send_word(24'h000000, 24'h000000);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            kind = ph % 4;
            ot = 3'($urandom_range(0, 7));
            op = 3'($urandom_range(0, 7));
            if (ph == PHASES - 2) begin
                ot = 3'd0;
                op = 3'd7;
            end
            if (ph == PHASES - 1) begin
                ot = 3'd7;
                op = 3'd0;
                idle_on = 1'b0;     // closing stretch at full rate
            end
            case (kind)
                0: load_cal(TYP_TEMP, TYP_PA, TYP_PB, TYP_PC, ot, op);
                1: load_cal(jitter(TYP_TEMP), jitter(TYP_PA), jitter(TYP_PB),
                            jitter(TYP_PC), ot, op);
                2: load_cal(rand48(), rand48(), rand48(), rand48(), ot, op);
                default: load_cal({48{1'b1}}, 48'h0, {48{1'b1}}, 48'h0, ot, op);
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 2 && n == 20)
                    hold_req = 1'b1;
                if ($urandom_range(0, 1) == 0) begin
                    // readings near a plausible operating point
                    rp = 24'h655AC0 + 24'($urandom_range(0, 24'h1FFFFF)) - 24'h0FFFFF;
                    rt = 24'h7EED00 + 24'($urandom_range(0, 24'h1FFFFF)) - 24'h0FFFFF;
                end else begin
                    rp = 24'($urandom);
                    rt = 24'($urandom);
                end
                send_word(rp, rt);
            end
            drain();
        end

        $display("covered %0d result words over %0d calibration settings, all OSR codes,",
                 checked, PHASES + 4);
        $display("divisor-zero case, random bubbles and a %0d-cycle output hold", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/baro_pkg.sv
hdl/baro_div.sv
hdl/baro_front.sv
hdl/baro_back.sv
hdl/baro_compensation_int32.sv
bench/baro_checker.sv
bench/tb_baro_compensation_int32.sv
